// ===== hw/rtl/spritz_pkg.sv =====
// Spritz sponge package: command codes, sequencer states, shuffle phases.
// No dependencies.
package spritz_pkg;

  localparam int unsigned PERM_SIZE_DEF = 256;

  typedef enum logic [2:0] {
    CMD_INIT    = 3'd0,
    CMD_ABSORB  = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_DRIP    = 3'd3,
    CMD_ENCRYPT = 3'd4,
    CMD_DECRYPT = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR,    // identity fill sweep
    ST_IDLE,
    ST_DISPATCH, // decide the next job for the item
    ST_U_RDI,    // update: read S[i]
    ST_U_RDJ1,   // read S[j + S[i]]
    ST_U_RDJ2,   // read S[j]
    ST_U_WR1,    // write S[i] <- S[j]
    ST_U_WR2,    // write S[j] <- S[i]
    ST_C_RD1,    // crush: read S[v]
    ST_C_RD2,    // read S[m]
    ST_C_WR1,
    ST_C_WR2,
    ST_A_RD1,    // nibble swap: read S[a]
    ST_A_RD2,
    ST_A_WR1,
    ST_A_WR2,
    ST_D_RD1,    // output: read S[z + k]
    ST_D_RD2,    // read S[i + .]
    ST_D_RD3,    // read S[j + .]
    ST_D_FIN,
    ST_W_STEP,   // step w to next coprime value
    ST_OUT
  } state_t;

  // phase inside a shuffle: whip crush whip crush whip
  typedef enum logic [2:0] {
    PH_W0, PH_C0, PH_W1, PH_C1, PH_W2, PH_NONE
  } phase_t;

endpackage

// ===== hw/rtl/spritz_sponge_cipher.sv =====
// Spritz sponge cipher top level: permutation in one synchronous RAM.
// Depends on spritz_pkg.
//
// Usage: commands arrive on cmd/data_byte with in_valid/in_ready; drip,
// encrypt and decrypt give one transfer on out_byte with out_valid/out_ready.
// Init, absorb byte and absorb stop give no output.
// One item at a time. Every permutation read goes through the single RAM port,
// whose read data is registered, so costs are set by that port.
// After reset (and on init) a fill sweep writes the identity permutation
// with in_ready low. A result waits in the output register while out_ready
// is low; the next item is taken only once it has gone.
module spritz_sponge_cipher
  import spritz_pkg::*;
#(
  parameter int unsigned PERM_SIZE = PERM_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] cmd,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);

  localparam int unsigned AW   = $clog2(PERM_SIZE);
  localparam int unsigned HALF = PERM_SIZE / 2;
  localparam int unsigned CW   = $clog2(2 * PERM_SIZE + 1);

  // sums stay below 16N for N >= 32, so four conditional subtracts reduce them
  function automatic logic [AW-1:0] md(input logic [8:0] v);
    logic [11:0] r;
    r = {3'b000, v};
    for (int s = 3; s >= 0; s--) begin
      if (r >= 12'(PERM_SIZE << s)) r = r - 12'(PERM_SIZE << s);
    end
    return r[AW-1:0];
  endfunction

  // memory
  logic [7:0]    mem [PERM_SIZE];
  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [7:0] idx_i, idx_j, idx_k, last_out, acount, step_w;
  logic [7:0] idx_i_next, idx_j_next, idx_k_next, last_out_next, acount_next, step_w_next;
  logic [2:0] cur_cmd, cur_cmd_next;
  logic [7:0] cur_data, cur_data_next;
  logic [1:0] nib, nib_next;          // nibbles done / update done
  logic [CW-1:0] cnt, cnt_next;
  logic [7:0] ta, tb, ta_next, tb_next;
  logic [AW-1:0] pa, pb, pa_next, pb_next;
  logic [7:0] res, res_next;
  logic       out_valid_r, out_valid_next;

  assign out_valid = out_valid_r;
  assign out_byte  = res;
  assign in_ready  = (state == ST_IDLE) && !out_valid_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR; phase <= PH_NONE;
      idx_i <= '0; idx_j <= '0; idx_k <= '0; last_out <= '0;
      acount <= '0; step_w <= 8'd1; cnt <= '0; nib <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state <= state_next; phase <= phase_next;
      idx_i <= idx_i_next; idx_j <= idx_j_next; idx_k <= idx_k_next;
      last_out <= last_out_next; acount <= acount_next; step_w <= step_w_next;
      cnt <= cnt_next; nib <= nib_next; out_valid_r <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_cmd <= cur_cmd_next; cur_data <= cur_data_next;
    ta <= ta_next; tb <= tb_next; pa <= pa_next; pb <= pb_next;
    res <= res_next;
  end

  // coprime flag for every 8-bit w, fixed at elaboration (subtractive gcd)
  function automatic logic [255:0] cop_mask();
    logic [255:0] m;
    int unsigned x, y;
    m = '0;
    for (int w = 1; w < 256; w++) begin
      x = unsigned'(w); y = PERM_SIZE;
      while (x != y) begin
        if (x > y) x = x - y;
        else y = y - x;
      end
      m[w] = (x == 1);
    end
    return m;
  endfunction

  localparam logic [255:0] COP_MASK = cop_mask();

  always_comb begin
    state_next = state; phase_next = phase;
    idx_i_next = idx_i; idx_j_next = idx_j; idx_k_next = idx_k;
    last_out_next = last_out; acount_next = acount; step_w_next = step_w;
    cur_cmd_next = cur_cmd; cur_data_next = cur_data;
    cnt_next = cnt; nib_next = nib;
    ta_next = ta; tb_next = tb; pa_next = pa; pb_next = pb;
    res_next = res; out_valid_next = out_valid_r;
    we = 1'b0; addr = '0; wdata = '0;
    if (out_valid_r && out_ready) out_valid_next = 1'b0;
    case (state)
      ST_CLEAR: begin
        we = 1'b1; addr = cnt[AW-1:0]; wdata = 8'(cnt[AW-1:0]);
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(PERM_SIZE - 1)) begin
          cnt_next = '0; state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cur_cmd_next = cmd; cur_data_next = data_byte; nib_next = '0;
          phase_next = PH_NONE;
          case (cmd)
            CMD_INIT: begin
              idx_i_next = '0; idx_j_next = '0; idx_k_next = '0;
              last_out_next = '0; acount_next = '0; step_w_next = 8'd1;
              cnt_next = '0; state_next = ST_CLEAR;
            end
            CMD_ABSORB, CMD_STOP, CMD_DRIP, CMD_ENCRYPT, CMD_DECRYPT:
              state_next = ST_DISPATCH;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DISPATCH: begin
        // shuffle phases run first when pending
        if (phase != PH_NONE) begin
          cnt_next = '0;
          state_next = (phase == PH_C0 || phase == PH_C1) ? ST_C_RD1 : ST_U_RDI;
        end else begin
          case (cur_cmd)
            CMD_ABSORB, CMD_STOP: begin
              if ((cur_cmd == CMD_STOP && nib == 2'd1) ||
                  (cur_cmd == CMD_ABSORB && nib == 2'd2)) begin
                state_next = ST_IDLE;
              end else if (acount == 8'(HALF)) begin
                phase_next = PH_W0; cnt_next = '0; state_next = ST_U_RDI;
              end else if (cur_cmd == CMD_STOP) begin
                acount_next = acount + 1'b1; nib_next = 2'd1;
              end else begin
                state_next = ST_A_RD1;
              end
            end
            default: begin
              if (nib == 2'd0 && acount != 0) begin
                phase_next = PH_W0; cnt_next = '0; state_next = ST_U_RDI;
              end else if (nib == 2'd0) begin
                state_next = ST_U_RDI;
              end else begin
                state_next = ST_D_RD1;
              end
            end
          endcase
        end
      end
      // update
      ST_U_RDI: begin
        idx_i_next = 8'(md(9'(idx_i) + 9'(step_w)));
        addr = md(9'(idx_i) + 9'(step_w));
        state_next = ST_U_RDJ1;
      end
      ST_U_RDJ1: begin
        ta_next = rdata; // S[i]
        addr = md(9'(idx_j) + 9'(rdata));
        state_next = ST_U_RDJ2;
      end
      ST_U_RDJ2: begin
        idx_j_next = 8'(md(9'(idx_k) + 9'(rdata)));
        addr = md(9'(idx_k) + 9'(rdata));
        state_next = ST_U_WR1;
      end
      ST_U_WR1: begin
        tb_next = rdata; // S[j]
        idx_k_next = 8'(md(9'(md(9'(idx_i) + 9'(idx_k))) + 9'(rdata)));
        we = 1'b1; addr = idx_i[AW-1:0]; wdata = rdata;
        state_next = ST_U_WR2;
      end
      ST_U_WR2: begin
        we = 1'b1; addr = idx_j[AW-1:0]; wdata = ta;
        if (phase == PH_NONE) begin
          nib_next = 2'd1; state_next = ST_DISPATCH;
        end else if (cnt == CW'(2 * PERM_SIZE - 1)) begin
          step_w_next = step_w + 1'b1; state_next = ST_W_STEP;
        end else begin
          cnt_next = cnt + 1'b1; state_next = ST_U_RDI;
        end
      end
      ST_W_STEP: begin
        if (COP_MASK[step_w]) begin
          case (phase)
            PH_W0: phase_next = PH_C0;
            PH_W1: phase_next = PH_C1;
            default: begin phase_next = PH_NONE; acount_next = '0; end
          endcase
          state_next = ST_DISPATCH;
        end else begin
          step_w_next = step_w + 1'b1;
        end
      end
      // crush
      ST_C_RD1: begin
        pa_next = cnt[AW-1:0];
        pb_next = AW'(PERM_SIZE - 1) - cnt[AW-1:0];
        addr = cnt[AW-1:0]; state_next = ST_C_RD2;
      end
      ST_C_RD2: begin
        ta_next = rdata; addr = pb; state_next = ST_C_WR1;
      end
      ST_C_WR1: begin
        tb_next = rdata;
        if (ta > rdata) begin
          we = 1'b1; addr = pa; wdata = rdata; state_next = ST_C_WR2;
        end else state_next = ST_C_WR2;
      end
      ST_C_WR2: begin
        if (ta > tb) begin we = 1'b1; addr = pb; wdata = ta; end
        if (cnt == CW'(HALF - 1)) begin
          phase_next = (phase == PH_C0) ? PH_W1 : PH_W2;
          cnt_next = '0; state_next = ST_DISPATCH;
        end else begin
          cnt_next = cnt + 1'b1; state_next = ST_C_RD1;
        end
      end
      // nibble swap
      ST_A_RD1: begin
        pa_next = acount[AW-1:0];
        pb_next = md(9'(HALF) + 9'(nib[0] ? cur_data[7:4] : cur_data[3:0]));
        addr = acount[AW-1:0]; state_next = ST_A_RD2;
      end
      ST_A_RD2: begin ta_next = rdata; addr = pb; state_next = ST_A_WR1; end
      ST_A_WR1: begin
        we = 1'b1; addr = pa; wdata = rdata; state_next = ST_A_WR2;
      end
      ST_A_WR2: begin
        we = 1'b1; addr = pb; wdata = ta;
        acount_next = acount + 1'b1; nib_next = nib + 1'b1;
        state_next = ST_DISPATCH;
      end
      // drip output
      ST_D_RD1: begin addr = md(9'(last_out) + 9'(idx_k)); state_next = ST_D_RD2; end
      ST_D_RD2: begin addr = md(9'(idx_i) + 9'(rdata)); state_next = ST_D_RD3; end
      ST_D_RD3: begin addr = md(9'(idx_j) + 9'(rdata)); state_next = ST_D_FIN; end
      ST_D_FIN: begin
        last_out_next = rdata;
        case (cur_cmd)
          CMD_ENCRYPT: res_next = cur_data + rdata;
          CMD_DECRYPT: res_next = cur_data - rdata;
          default:     res_next = rdata;
        endcase
        out_valid_next = 1'b1; state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid);
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_D_FIN) |=> out_valid) else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready) else $error("accept during fill");

endmodule
